// ===== hw/rtl/kdrs_pkg.sv =====
// shared types and constants of the kd-tree radius search block
`default_nettype none

package kdrs_pkg;

  localparam int COORD_BITS    = 24;
  localparam int RADIUS_BITS   = 20;
  localparam int ELEM_BITS     = 15;
  localparam int POINT_BITS    = 12;
  localparam int COUNT_BITS    = 11;
  localparam int POS_BITS      = 10;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 11'd2047;
  localparam logic [COUNT_BITS-1:0] NODES_RST  = 11'd1024;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_SOUGHT = 2'd1,
    CFG_NODES  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    cmd_e                          command;
    logic [POS_BITS-1:0]           node_position;
    logic                          node_present;
    logic [POINT_BITS-1:0]         point_index;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic [ELEM_BITS-1:0]          element_code;
  } in_t;

  typedef struct packed {
    logic                   match_found;
    logic [POINT_BITS-1:0]  match_point;
    logic [COUNT_BITS-1:0]  match_count;
    logic                   truncated;
    logic                   last;
  } out_t;

  typedef struct packed {
    logic [RADIUS_BITS-1:0] radius;
    logic [ELEM_BITS-1:0]   sought;
  } cfg_t;

  // queue entry: the transaction plus what the front worked out about it
  typedef struct packed {
    in_t  data;
    logic pos_ok;
  } item_t;

  typedef struct packed {
    logic                          present;
    logic [POINT_BITS-1:0]         point;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic signed [COORD_BITS-1:0]  z;
    logic [ELEM_BITS-1:0]          element;
  } node_t;

  function automatic axis_e next_axis(axis_e a);
    axis_e r;
    case (a)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] coord_of(node_t n, axis_e a);
    logic signed [COORD_BITS-1:0] r;
    case (a)
      AXIS_X:  r = n.x;
      AXIS_Y:  r = n.y;
      default: r = n.z;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kd_tree_radius_search.sv =====
// top level of the kd-tree radius search block
`default_nettype none

// kd-tree radius search over a 3d tree kept in heap order (children of node i at
// 2i+1 and 2i+2, split axis x, y, z by level). a load transaction writes one node
// and leaves the walker idle; a query transaction walks the tree in preorder, left
// child first, and returns one result per match (at most MAX_EMITTED, the last
// carrying the total and the truncation flag) or a single no-match result. per
// visited node a query passes ST_POP, ST_GAP, ST_SQ and ST_SUM (only ST_POP and
// ST_GAP when the root is empty), ends the walk in ST_POP and passes ST_RD and
// ST_SHOW for each result; the per-node steps come from the single read port
// of the node memory, which fetches the node and then each of its two children.
// a two-entry queue in front lets transactions be taken while a walk is running.
// the node memory has no reset: a node must be loaded before any query can reach
// it. configuration writes are always taken and must only happen while idle.
module kd_tree_radius_search #(
  parameter int TREE_NODES  = 1024,
  parameter int MAX_EMITTED = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  kdrs_pkg::in_t                         in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output kdrs_pkg::out_t                        out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kdrs_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [kdrs_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import kdrs_pkg::*;

  localparam int AW = $clog2(TREE_NODES);
  localparam int KW = (AW + 2 > COUNT_BITS) ? AW + 2 : COUNT_BITS;

  logic [RADIUS_BITS-1:0] radius_q;
  logic [ELEM_BITS-1:0]   sought_q;
  logic [COUNT_BITS-1:0]  nodes_q;
  logic [KW-1:0]          nodes_ext, limit;
  cfg_t                   cfg;
  logic                   item_valid, item_ready;
  item_t                  item;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      sought_q <= '0;
      nodes_q  <= NODES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_SOUGHT: sought_q <= cfg_data_i[ELEM_BITS-1:0];
        CFG_NODES:  nodes_q  <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // positions past the tree size count as absent, whatever is programmed
  assign nodes_ext  = KW'(nodes_q);
  assign limit      = (nodes_ext < KW'(TREE_NODES)) ? nodes_ext : KW'(TREE_NODES);
  assign cfg.radius = radius_q;
  assign cfg.sought = sought_q;

  kdrs_front #(
    .TREE_NODES (TREE_NODES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  kdrs_back #(
    .TREE_NODES  (TREE_NODES),
    .MAX_EMITTED (MAX_EMITTED)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .cfg_i        (cfg),
    .limit_i      (limit),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/kdrs_front.sv =====
// front end: accepts transactions, classifies them and queues them for the walker
`default_nettype none

module kdrs_front #(
  parameter int TREE_NODES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kdrs_pkg::in_t   in_data_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output kdrs_pkg::item_t item_o
);
  import kdrs_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      cls;

  // loads aimed past the end of the tree are dropped
  always_comb begin
    cls.data   = in_data_i;
    cls.pos_ok = 32'(in_data_i.node_position) < 32'(TREE_NODES);
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kdrs_back.sv =====
// back end: node memory, tree walk sequencer, match buffer and result output
`default_nettype none

module kdrs_back #(
  parameter int TREE_NODES  = 1024,
  parameter int MAX_EMITTED = 64,
  localparam int AW = $clog2(TREE_NODES),
  localparam int KW = (AW + 2 > kdrs_pkg::COUNT_BITS) ? AW + 2 : kdrs_pkg::COUNT_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  kdrs_pkg::item_t item_i,
  input  kdrs_pkg::cfg_t  cfg_i,
  input  logic [KW-1:0]   limit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output kdrs_pkg::out_t  out_data_o
);
  import kdrs_pkg::*;

  localparam int SD  = AW + 2;
  localparam int SPW = $clog2(SD + 1);
  localparam int SIW = $clog2(SD);
  localparam int EW  = $clog2(MAX_EMITTED + 1);
  localparam int BW  = (MAX_EMITTED > 1) ? $clog2(MAX_EMITTED) : 1;
  localparam int QW  = 2 * RADIUS_BITS;
  localparam int SW  = QW + 2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_POP  = 7'b0000010,
    ST_GAP  = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_SHOW = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [AW-1:0] pos;
    axis_e         axis;
  } frame_t;

  state_e state_q, state_d;

  node_t         node_mem_q [TREE_NODES];
  node_t         rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic signed [COORD_BITS-1:0] tgt_q [3];
  logic [QW-1:0]          rsq_q;
  frame_t                 stack_q [SD];
  logic [SPW-1:0]         sp_q, sp_m1;
  frame_t                 top;
  logic [AW-1:0]          cur_pos_q;
  axis_e                  cur_axis_q;
  logic [ELEM_BITS-1:0]   cur_elem_q;
  logic [POINT_BITS-1:0]  cur_point_q;
  logic [RADIUS_BITS-1:0] gap_q [3];
  logic                   outr_q, far_q, tgt_gt_q;
  logic signed [COORD_BITS-1:0] cur_ax_q;
  logic [QW-1:0]          sq_q [3];
  logic                   pres_r_q, viab_r_q;
  logic [COUNT_BITS-1:0]  found_q;
  logic [EW-1:0]          emitted_q, k_q, k_nx;
  logic [POINT_BITS-1:0]  buf_q [MAX_EMITTED];
  logic [POINT_BITS-1:0]  buf_rd_q;

  logic [COORD_BITS:0]    gap_abs [3];
  logic [2:0]             gap_big;
  logic signed [COORD_BITS-1:0] cur_c, tgt_c, ch_c;
  logic [KW-1:0]          kid_l, kid_r;
  logic                   kid_pres, kid_viab;
  logic [SW-1:0]          dist_sq;
  logic                   in_range, is_match, push_r, push_l, fin;
  logic                   take;

  assign item_ready_o = (state_q == ST_IDLE);
  assign take         = item_valid_i && item_ready_o;
  assign mem_we       = take && (item_i.data.command == CMD_LOAD) && item_i.pos_ok;

  assign sp_m1 = sp_q - SPW'(1);
  assign top   = stack_q[sp_m1[SIW-1:0]];
  assign kid_l = (KW'(cur_pos_q) << 1) + KW'(1);
  assign kid_r = kid_l + KW'(1);

  always_comb begin
    case (state_q)
      ST_GAP:  rd_addr = AW'(kid_r);
      ST_SQ:   rd_addr = AW'(kid_l);
      default: rd_addr = top.pos;
    endcase
  end

  // node memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem_q[AW'(item_i.data.node_position)] <= '{
        present: item_i.data.node_present, point: item_i.data.point_index,
        x: item_i.data.coord_x, y: item_i.data.coord_y, z: item_i.data.coord_z,
        element: item_i.data.element_code};
    end
    rd_q <= node_mem_q[rd_addr];
  end

  // per-axis distance from target to the node just read
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [COORD_BITS-1:0] nc;
      logic signed [COORD_BITS:0]   diff;
      nc   = coord_of(rd_q, axis_e'(a));
      diff = {tgt_q[a][COORD_BITS-1], tgt_q[a]} - {nc[COORD_BITS-1], nc};
      gap_abs[a] = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
      gap_big[a] = gap_abs[a] > (COORD_BITS+1)'(cfg_i.radius);
    end
    cur_c = coord_of(rd_q, cur_axis_q);
    case (cur_axis_q)
      AXIS_X:  tgt_c = tgt_q[0];
      AXIS_Y:  tgt_c = tgt_q[1];
      default: tgt_c = tgt_q[2];
    endcase
  end

  // child test against the split plane of the current node
  always_comb begin
    ch_c     = coord_of(rd_q, cur_axis_q);
    kid_viab = tgt_gt_q ? !((cur_ax_q > ch_c) && far_q) : !((cur_ax_q < ch_c) && far_q);
    kid_pres = rd_q.present && ((state_q == ST_SQ) ? (kid_r < limit_i) : (kid_l < limit_i));
  end

  always_comb begin
    dist_sq  = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    in_range = !outr_q && (dist_sq < SW'(rsq_q));
    is_match = in_range && (cur_elem_q == cfg_i.sought);
    push_r   = pres_r_q && (in_range || viab_r_q);
    push_l   = kid_pres && (in_range || kid_viab);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          tgt_q[0]   <= item_i.data.coord_x;
          tgt_q[1]   <= item_i.data.coord_y;
          tgt_q[2]   <= item_i.data.coord_z;
          rsq_q      <= QW'(cfg_i.radius) * QW'(cfg_i.radius);
          stack_q[0] <= '{pos: '0, axis: AXIS_X};
        end
      end
      ST_POP: begin
        cur_pos_q  <= top.pos;
        cur_axis_q <= top.axis;
      end
      ST_GAP: begin
        for (int a = 0; a < 3; a++) gap_q[a] <= gap_abs[a][RADIUS_BITS-1:0];
        outr_q      <= |gap_big;
        far_q       <= gap_big[cur_axis_q];
        tgt_gt_q    <= tgt_c > cur_c;
        cur_ax_q    <= cur_c;
        cur_elem_q  <= rd_q.element;
        cur_point_q <= rd_q.point;
      end
      ST_SQ: begin
        for (int a = 0; a < 3; a++) sq_q[a] <= QW'(gap_q[a]) * QW'(gap_q[a]);
        pres_r_q <= kid_pres;
        viab_r_q <= kid_viab;
      end
      ST_SUM: begin
        // right child goes below the left one so the left is walked first
        if (push_r) begin
          stack_q[sp_q[SIW-1:0]] <= '{pos: AW'(kid_r), axis: next_axis(cur_axis_q)};
        end
        if (push_l) begin
          stack_q[push_r ? SIW'(sp_q + SPW'(1)) : sp_q[SIW-1:0]]
            <= '{pos: AW'(kid_l), axis: next_axis(cur_axis_q)};
        end
      end
      default: ;
    endcase
  end

  // match buffer
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM && is_match && emitted_q < EW'(MAX_EMITTED)) begin
      buf_q[emitted_q[BW-1:0]] <= cur_point_q;
    end
    buf_rd_q <= buf_q[k_q[BW-1:0]];
  end

  assign k_nx = k_q + EW'(1);
  assign fin  = (k_nx == emitted_q) || (emitted_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take && item_i.data.command == CMD_QUERY) state_d = ST_POP;
      ST_POP:  state_d = (sp_q == '0) ? ST_RD : ST_GAP;
      ST_GAP:  state_d = rd_q.present ? ST_SQ : ST_POP;
      ST_SQ:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_POP;
      ST_RD:   state_d = ST_SHOW;
      ST_SHOW: if (out_ready_i) state_d = fin ? ST_IDLE : ST_RD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sp_q      <= '0;
      found_q   <= '0;
      emitted_q <= '0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (take && item_i.data.command == CMD_QUERY) begin
            sp_q      <= SPW'(1);
            found_q   <= '0;
            emitted_q <= '0;
          end
        end
        ST_POP: begin
          if (sp_q == '0) k_q <= '0;
          else            sp_q <= sp_m1;
        end
        ST_SUM: begin
          sp_q <= sp_q + SPW'(push_r) + SPW'(push_l);
          if (is_match) begin
            if (emitted_q < EW'(MAX_EMITTED)) emitted_q <= emitted_q + EW'(1);
            if (found_q != COUNT_MAX) found_q <= found_q + COUNT_BITS'(1);
          end
        end
        ST_SHOW: if (out_ready_i && !fin) k_q <= k_nx;
        default: ;
      endcase
    end
  end

  assign out_valid_o = (state_q == ST_SHOW);

  always_comb begin
    out_data_o = '0;
    out_data_o.last = fin;
    if (emitted_q != '0) begin
      out_data_o.match_found = 1'b1;
      out_data_o.match_point = buf_rd_q;
      out_data_o.match_count = fin ? found_q : COUNT_BITS'(k_nx);
      out_data_o.truncated   = fin && (found_q > COUNT_BITS'(emitted_q));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kdrs_checker.sv =====
// port-level checks of the kd-tree radius search block and their bind
`default_nettype none

module kdrs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input kdrs_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.match_found |-> out_data_o.last)
    else $error("no-match result not final");

  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !out_data_o.truncated)
    else $error("truncation flagged before the final result");

endmodule

bind kd_tree_radius_search kdrs_checker u_kdrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
